@@ rtl/core/mspd_pkg.sv @@
// ----------------------------------------------------------------------------
// mspd_pkg
// Shared types, constants and helpers for the motor speed PID drive core.
// ----------------------------------------------------------------------------
package mspd_pkg;

  localparam int CFG_IDX_W  = 4;
  localparam int CFG_DATA_W = 24;
  localparam int MUL_W      = 25;
  localparam int PROD_W     = 2 * MUL_W;
  localparam int ACC_W      = 42;

  // register indexes on the configuration port
  typedef enum logic [CFG_IDX_W-1:0] {
    REG_SETPOINT       = 4'd0,
    REG_SPEED_SCALE    = 4'd1,
    REG_SAMPLE_PERIOD  = 4'd2,
    REG_INVERSE_PERIOD = 4'd3,
    REG_GAIN_P         = 4'd4,
    REG_GAIN_I         = 4'd5,
    REG_GAIN_D         = 4'd6,
    REG_INTEGRAL_LIMIT = 4'd7
  } reg_idx_t;

  localparam logic [23:0] SPEED_SCALE_RST    = 24'd1536000;
  localparam logic [15:0] SAMPLE_PERIOD_RST  = 16'd655;
  localparam logic [15:0] INVERSE_PERIOD_RST = 16'd100;
  localparam logic [22:0] INTEGRAL_LIMIT_RST = 23'd65280;

  localparam logic signed [PROD_W-1:0] Q24_MAX = PROD_W'(64'sd8388607);
  localparam logic signed [PROD_W-1:0] Q24_MIN = PROD_W'(-64'sd8388608);

  // correction limit: 255 in Q.16
  localparam logic signed [ACC_W-1:0] CORR_MAX = ACC_W'(64'sd16711680);
  localparam logic signed [ACC_W-1:0] CORR_MIN = ACC_W'(-64'sd16711680);

  typedef struct packed {
    logic               func;
    logic signed [15:0] pulse_count;
  } in_t;

  typedef struct packed {
    logic signed [23:0] measured_speed;
    logic [7:0]         duty;
    logic               bridge_in1;
    logic               bridge_in2;
  } out_t;

  function automatic logic signed [23:0] sat24(input logic signed [PROD_W-1:0] v);
    if (v > Q24_MAX) begin
      return 24'sh7FFFFF;
    end else if (v < Q24_MIN) begin
      return 24'sh800000;
    end else begin
      return v[23:0];
    end
  endfunction

endpackage

@@ rtl/core/mspd_mul.sv @@
// ----------------------------------------------------------------------------
// mspd_mul
// Shared signed 25x25 multiplier with a registered product.
// ----------------------------------------------------------------------------
module mspd_mul (
  input  logic                                 clk,
  input  logic signed [mspd_pkg::MUL_W-1:0]    a,
  input  logic signed [mspd_pkg::MUL_W-1:0]    b,
  output logic signed [mspd_pkg::PROD_W-1:0]   prod
);
  import mspd_pkg::*;

  always_ff @(posedge clk) begin
    prod <= a * b;
  end

endmodule

@@ rtl/core/motor_speed_pid_drive_core.sv @@
// ----------------------------------------------------------------------------
// motor_speed_pid_drive_core
// PID speed controller with clamped integral and H-bridge direction/duty out.
// ----------------------------------------------------------------------------
// Usage:
//   in channel  : in_valid / in_stall / in_data (func, pulse_count). A
//                 transaction happens when in_valid is high and in_stall low.
//   out channel : out_valid / out_stall / out_data (measured_speed, duty,
//                 bridge_in1, bridge_in2), same rule.
//   cfg channel : cfg_valid / cfg_ready / cfg_index / cfg_data; cfg_ready is
//                 always high. Indexes above 7 are dropped. Write only when idle.
// Sequence:
//   A control sample runs through eight steps M0..M7, six of them feeding
//   the one shared 25x25 multiplier (speed, derivative, integral step and
//   the three gain products), plus the finish step, which loads the output
//   register. A stop item goes straight to the finish step. in_stall is high
//   while an item is in the sequencer, so a new item is taken only once the
//   last one has left the finish step.
// Stall:
//   The result sits in an output register; the core accepts the next item
//   while it waits, and holds in its finish step until the register frees.
// Reset:
//   rst (synchronous, active high) loads register defaults, clears the PID
//   state and arms the first-sample flag (derivative forced to zero).
// ----------------------------------------------------------------------------
module motor_speed_pid_drive_core (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               in_valid,
  output logic                               in_stall,
  input  mspd_pkg::in_t                      in_data,
  output logic                               out_valid,
  input  logic                               out_stall,
  output mspd_pkg::out_t                     out_data,
  input  logic                               cfg_valid,
  output logic                               cfg_ready,
  input  logic [mspd_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [mspd_pkg::CFG_DATA_W-1:0]    cfg_data
);
  import mspd_pkg::*;

  typedef enum logic [3:0] {
    S_IDLE, S_M0, S_M1, S_M2, S_M3, S_M4, S_M5, S_M6, S_M7, S_FIN
  } state_t;

  // configuration registers
  logic signed [23:0] setpoint;
  logic [23:0]        speed_scale;
  logic [15:0]        sample_period;
  logic [15:0]        inverse_period;
  logic signed [15:0] gain_p;
  logic signed [15:0] gain_i;
  logic signed [15:0] gain_d;
  logic [22:0]        integral_limit;

  // controller state
  logic signed [23:0] previous_error;
  logic signed [23:0] integral_sum;
  logic               first_sample;

  // working registers
  state_t               state;
  logic                 stop;
  logic signed [15:0]   count;
  logic signed [23:0]   speed;
  logic signed [23:0]   err;
  logic signed [23:0]   deriv;
  logic signed [ACC_W-1:0] acc;

  logic signed [MUL_W-1:0]  mul_a;
  logic signed [MUL_W-1:0]  mul_b;
  logic signed [PROD_W-1:0] prod;

  // datapath intermediates
  logic signed [23:0]       speed_next;
  logic signed [24:0]       err_diff;
  logic signed [23:0]       err_next;
  logic signed [24:0]       integ_sum;
  logic signed [24:0]       lim;
  logic signed [23:0]       integral_next;
  logic signed [ACC_W-1:0]  corr_clamp;
  logic signed [24:0]       corr;
  logic signed [24:0]       corr_abs;
  logic                     out_free;
  logic                     out_valid_next;

  assign cfg_ready = 1'b1;
  assign in_stall  = (state != S_IDLE);
  assign out_free  = !out_valid || !out_stall;

  // load from the finish step, otherwise hold while stalled
  assign out_valid_next = ((state == S_FIN) && out_free) || (out_valid && out_stall);

  mspd_mul u_mul (
    .clk  (clk),
    .a    (mul_a),
    .b    (mul_b),
    .prod (prod)
  );

  // operand select for the shared multiplier
  always_comb begin
    mul_a = '0;
    mul_b = '0;
    case (state)
      S_M0: begin
        mul_a = MUL_W'(count);
        mul_b = $signed({1'b0, speed_scale});
      end
      S_M2: begin
        mul_a = MUL_W'(err) - MUL_W'(previous_error);
        mul_b = $signed({9'b0, inverse_period});
      end
      S_M3: begin
        mul_a = MUL_W'(err);
        mul_b = $signed({9'b0, sample_period});
      end
      S_M4: begin
        mul_a = MUL_W'(gain_p);
        mul_b = MUL_W'(err);
      end
      S_M5: begin
        mul_a = MUL_W'(gain_d);
        mul_b = MUL_W'(deriv);
      end
      S_M6: begin
        mul_a = MUL_W'(gain_i);
        mul_b = MUL_W'(integral_sum);
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  always_comb begin
    // speed and error, product from S_M0
    speed_next = sat24(prod >>> 8);
    err_diff   = 25'(setpoint) - 25'(speed_next);
    err_next   = sat24(PROD_W'(err_diff));

    // integral step, product from S_M3
    integ_sum = 25'(integral_sum) + 25'(prod >>> 16);
    lim       = $signed({2'b0, integral_limit});
    if (integ_sum > lim) begin
      integral_next = lim[23:0];
    end else if (integ_sum < -lim) begin
      integral_next = 24'(-lim);
    end else begin
      integral_next = integ_sum[23:0];
    end

    // correction saturate and magnitude
    if (acc > CORR_MAX) begin
      corr_clamp = CORR_MAX;
    end else if (acc < CORR_MIN) begin
      corr_clamp = CORR_MIN;
    end else begin
      corr_clamp = acc;
    end
    corr     = corr_clamp[24:0];
    corr_abs = corr[24] ? -corr : corr;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      setpoint       <= '0;
      speed_scale    <= SPEED_SCALE_RST;
      sample_period  <= SAMPLE_PERIOD_RST;
      inverse_period <= INVERSE_PERIOD_RST;
      gain_p         <= '0;
      gain_i         <= '0;
      gain_d         <= '0;
      integral_limit <= INTEGRAL_LIMIT_RST;
      previous_error <= '0;
      integral_sum   <= '0;
      first_sample   <= 1'b1;
      state          <= S_IDLE;
      out_valid      <= 1'b0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        case (reg_idx_t'(cfg_index))
          REG_SETPOINT:       setpoint       <= $signed(cfg_data);
          REG_SPEED_SCALE:    speed_scale    <= cfg_data;
          REG_SAMPLE_PERIOD:  sample_period  <= cfg_data[15:0];
          REG_INVERSE_PERIOD: inverse_period <= cfg_data[15:0];
          REG_GAIN_P:         gain_p         <= $signed(cfg_data[15:0]);
          REG_GAIN_I:         gain_i         <= $signed(cfg_data[15:0]);
          REG_GAIN_D:         gain_d         <= $signed(cfg_data[15:0]);
          REG_INTEGRAL_LIMIT: integral_limit <= cfg_data[22:0];
          default: ;
        endcase
      end

      out_valid <= out_valid_next;

      case (state)
        S_IDLE: begin
          if (in_valid) begin
            stop  <= in_data.func;
            count <= in_data.pulse_count;
            state <= in_data.func ? S_FIN : S_M0;
          end
        end
        S_M0: state <= S_M1;
        S_M1: begin
          speed <= speed_next;
          err   <= err_next;
          state <= S_M2;
        end
        S_M2: state <= S_M3;
        S_M3: begin
          deriv <= first_sample ? 24'sd0 : sat24(prod);
          state <= S_M4;
        end
        S_M4: begin
          integral_sum <= integral_next;
          state        <= S_M5;
        end
        S_M5: begin
          acc   <= ACC_W'(prod);
          state <= S_M6;
        end
        S_M6: begin
          acc   <= acc + ACC_W'(prod);
          state <= S_M7;
        end
        S_M7: begin
          acc   <= acc + ACC_W'(prod);
          state <= S_FIN;
        end
        S_FIN: begin
          if (out_free) begin
            state <= S_IDLE;
            if (stop) begin
              out_data.measured_speed <= '0;
              out_data.duty           <= '0;
              out_data.bridge_in1     <= 1'b1;
              out_data.bridge_in2     <= 1'b1;
            end else begin
              out_data.measured_speed <= speed;
              out_data.duty           <= corr_abs[23:16];
              out_data.bridge_in1     <= !corr[24] && (corr != '0);
              out_data.bridge_in2     <= corr[24];
              previous_error          <= err;
              first_sample            <= 1'b0;
            end
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule

@@ dv/motor_speed_pid_drive_core_tb.sv @@
// ----------------------------------------------------------------------------
// motor_speed_pid_drive_core_tb
// Self-checking bench for the PID speed drive core. A directed table walks
// the field extremes, stop items, small corrections, zero periods and
// saturating gains. Random register settings and encoder counts follow. Every
// result is checked against its typed row or a cycle-free bench model of
// the controller, with random idle gaps and output stalls on both channels.
// ----------------------------------------------------------------------------
module motor_speed_pid_drive_core_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import mspd_pkg::*;

  // item codes on the func bit
  localparam logic FUNC_SAMPLE = 1'b0;
  localparam logic FUNC_STOP   = 1'b1;

  localparam int REG_COUNT      = 8;
  localparam logic [CFG_IDX_W-1:0] CFG_IDX_UNUSED = {CFG_IDX_W{1'b1}};

  // config value styles for the random phases
  localparam int MODE_MODEST = 0;
  localparam int MODE_ANY    = 1;
  localparam int MODE_EDGE   = 2;

  localparam int  NUM_PHASES      = 6;
  localparam int  PHASE_ITEMS     = 100;
  localparam int  LONG_HOLD       = 80;    // receiver hold-off, in cycles
  localparam int  TAIL_CYCLES     = 24;    // outlasts a sample's trip through the core
  localparam int  CYCLE_LIMIT     = 200000;

  localparam longint SPD_MAX   = 64'sd8388607;
  localparam longint SPD_MIN   = -64'sd8388608;
  localparam longint DUTY_FULL = 64'sd255;
  localparam longint CORR_LIM  = DUTY_FULL <<< 16;

  typedef enum logic {ROW_WRITE, ROW_ITEM} row_kind_t;

  typedef struct {
    row_kind_t             kind;
    logic [CFG_IDX_W-1:0]  idx;
    logic [CFG_DATA_W-1:0] val;
    in_t                   item;
    logic                  known;   // expected result typed into the row
    out_t                  want;
  } plan_row_t;

  // --------------------------------------------------------------------------
  // DUT hookup; every input starts at a known value
  // --------------------------------------------------------------------------
  logic                  clk = 1'b0;
  logic                  rst = 1'b1;
  logic                  in_valid = 1'b0;
  logic                  in_stall;
  in_t                   in_data = '0;
  logic                  out_valid;
  logic                  out_stall = 1'b1;
  out_t                  out_data;
  logic                  cfg_valid = 1'b0;
  logic                  cfg_ready;
  logic [CFG_IDX_W-1:0]  cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data = '0;

  motor_speed_pid_drive_core dut (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  // --------------------------------------------------------------------------
  // Controller model: shadow registers and PID state, reset values
  // --------------------------------------------------------------------------
  longint sh_setpoint = 0;
  longint sh_scale    = longint'(SPEED_SCALE_RST);
  longint sh_period   = longint'(SAMPLE_PERIOD_RST);
  longint sh_inv      = longint'(INVERSE_PERIOD_RST);
  longint sh_kp       = 0;
  longint sh_ki       = 0;
  longint sh_kd       = 0;
  longint sh_limit    = longint'(INTEGRAL_LIMIT_RST);

  longint st_prev_err = 0;
  longint st_integral = 0;
  bit     st_first    = 1'b1;

  out_t   drive_expected_q[$];

  // tag that rides along with the item being offered
  logic   row_known = 1'b0;
  out_t   row_want  = '0;

  int     fails = 0;
  int     n_samples = 0;
  int     n_stops = 0;
  int     n_results = 0;
  int     n_writes = 0;
  int     n_speed_sat = 0;
  int     cycle_count = 0;

  // receiver pacing; the sender asks for long hold-offs through hold_asks
  bit     send_quiet = 1'b0;
  bit     rcv_quiet = 1'b0;
  int     hold_asks = 0;
  int     hold_done = 0;

  function automatic longint clip(longint v, longint lo, longint hi);
    return (v < lo) ? lo : ((v > hi) ? hi : v);
  endfunction

  // Register write as the core sees it; indexes past the last register drop.
  function automatic void shadow_write(logic [CFG_IDX_W-1:0] idx,
                                       logic [CFG_DATA_W-1:0] val);
    case (idx)
      REG_SETPOINT:       sh_setpoint = longint'($signed(val));
      REG_SPEED_SCALE:    sh_scale    = longint'(val);
      REG_SAMPLE_PERIOD:  sh_period   = longint'(val[15:0]);
      REG_INVERSE_PERIOD: sh_inv      = longint'(val[15:0]);
      REG_GAIN_P:         sh_kp       = longint'($signed(val[15:0]));
      REG_GAIN_I:         sh_ki       = longint'($signed(val[15:0]));
      REG_GAIN_D:         sh_kd       = longint'($signed(val[15:0]));
      REG_INTEGRAL_LIMIT: sh_limit    = longint'(val[22:0]);
      default: ;
    endcase
  endfunction

  // One accepted item -> expected drive output, advancing the PID state.
  // All shifts are arithmetic on signed 64-bit values, so they floor.
  function automatic out_t next_drive(in_t it);
    longint spd, err, drv, stp, corr, mag;
    out_t   r;
    r = '0;
    if (it.func == FUNC_STOP) begin
      // brake: both bridge legs high, state untouched
      r.bridge_in1 = 1'b1;
      r.bridge_in2 = 1'b1;
      return r;
    end
    spd = clip((longint'($signed(it.pulse_count)) * sh_scale) >>> 8, SPD_MIN, SPD_MAX);
    err = clip(sh_setpoint - spd, SPD_MIN, SPD_MAX);
    if (st_first) begin
      drv = 0;
      st_first = 1'b0;
    end else begin
      drv = clip((err - st_prev_err) * sh_inv, SPD_MIN, SPD_MAX);
    end
    stp = (err * sh_period) >>> 16;
    st_integral = clip(st_integral + stp, -sh_limit, sh_limit);
    corr = sh_kp * err + sh_ki * st_integral + sh_kd * drv;
    corr = clip(corr, -CORR_LIM, CORR_LIM);
    st_prev_err = err;
    mag = (corr < 0) ? -corr : corr;
    r.measured_speed = spd[23:0];
    r.duty           = 8'(mag >>> 16);
    r.bridge_in1     = (corr > 0);
    r.bridge_in2     = (corr < 0);
    if (spd == SPD_MAX || spd == SPD_MIN) n_speed_sat++;
    return r;
  endfunction

  // --------------------------------------------------------------------------
  // Table row builders
  // --------------------------------------------------------------------------
  function automatic plan_row_t w_row(logic [CFG_IDX_W-1:0] idx,
                                      logic [CFG_DATA_W-1:0] val);
    plan_row_t r;
    r = '{kind: ROW_WRITE, idx: idx, val: val, item: '0, known: 1'b0, want: '0};
    return r;
  endfunction

  function automatic plan_row_t i_row(logic fn, logic signed [15:0] cnt);
    plan_row_t r;
    r = '{kind: ROW_ITEM, idx: '0, val: '0, item: '0, known: 1'b0, want: '0};
    r.item.func        = fn;
    r.item.pulse_count = cnt;
    return r;
  endfunction

  function automatic plan_row_t k_row(logic fn, logic signed [15:0] cnt,
                                      logic signed [23:0] spd, logic in1, logic in2);
    plan_row_t r;
    r = i_row(fn, cnt);
    r.known               = 1'b1;
    r.want.measured_speed = spd;
    r.want.duty           = 8'd0;
    r.want.bridge_in1     = in1;
    r.want.bridge_in2     = in2;
    return r;
  endfunction

  // --------------------------------------------------------------------------
  // Random values
  // --------------------------------------------------------------------------
  function automatic int reg_width(int r);
    case (r)
      REG_SETPOINT, REG_SPEED_SCALE: return 24;
      REG_INTEGRAL_LIMIT:            return 23;
      default:                       return 16;
    endcase
  endfunction

  function automatic bit reg_signed(int r);
    return (r == REG_SETPOINT || r == REG_GAIN_P || r == REG_GAIN_I || r == REG_GAIN_D);
  endfunction

  function automatic logic [CFG_DATA_W-1:0] reg_value(int r, int mode);
    int                    w;
    logic [CFG_DATA_W-1:0] mask, v;
    w    = reg_width(r);
    mask = CFG_DATA_W'((64'd1 << w) - 64'd1);
    if (mode == MODE_EDGE) begin
      if ($urandom_range(0, 1) == 1) begin
        v = reg_signed(r) ? (mask >> 1) : mask;
      end else if (reg_signed(r)) begin
        v = CFG_DATA_W'(1) << (w - 1);
      end else begin
        v = (r == REG_SAMPLE_PERIOD || r == REG_INVERSE_PERIOD) ? CFG_DATA_W'(1) : '0;
      end
    end else if (mode == MODE_ANY) begin
      v = CFG_DATA_W'($urandom) & mask;
    end else begin
      // modest magnitude, random sign where the register is signed
      v = CFG_DATA_W'($urandom_range(0, 1 << (w - 6)));
      if (reg_signed(r) && $urandom_range(0, 1) == 1) v = (-v) & mask;
      if ((r == REG_SAMPLE_PERIOD || r == REG_INVERSE_PERIOD) && v == '0) begin
        v = CFG_DATA_W'(1);
      end
    end
    return v;
  endfunction

  function automatic in_t rand_item();
    in_t it;
    int  pick;
    it.func = ($urandom_range(0, 7) == 0) ? FUNC_STOP : FUNC_SAMPLE;
    pick    = $urandom_range(0, 9);
    if (pick < 5)       it.pulse_count = 16'($signed($urandom_range(0, 400)) - 200);
    else if (pick < 8)  it.pulse_count = 16'($urandom);
    else if (pick == 8) it.pulse_count = 16'sh7FFF;
    else                it.pulse_count = 16'sh8000;
    return it;
  endfunction

  // --------------------------------------------------------------------------
  // Channel tasks (inputs change only by NBA at a rising edge)
  // --------------------------------------------------------------------------
  task automatic send_item(in_t it, logic known, out_t want);
    int gap;
    gap = send_quiet ? 0 : $urandom_range(0, 4);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid  <= 1'b1;
    in_data   <= it;
    row_known <= known;
    row_want  <= want;
    do @(posedge clk); while (in_stall);
  endtask

  // Sender pause: nothing offered until every expected result has come.
  task automatic wait_drain();
    in_valid <= 1'b0;
    do @(posedge clk); while (drive_expected_q.size() != 0);
  endtask

  // cfg_valid stays up across a burst; the caller lowers it afterwards
  task automatic cfg_write(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    do @(posedge clk); while (!cfg_ready);
    shadow_write(idx, val);
    n_writes++;
  endtask

  task automatic program_phase(int phase);
    int mode;
    wait_drain();
    for (int r = 0; r < REG_COUNT; r++) begin
      if (phase == NUM_PHASES - 1)  mode = MODE_EDGE;
      else if (phase == 0)          mode = MODE_MODEST;
      else                          mode = $urandom_range(MODE_MODEST, MODE_EDGE);
      cfg_write(CFG_IDX_W'(r), reg_value(r, mode));
    end
    // a write to an unmapped index must not disturb anything
    cfg_write(CFG_IDX_W'($urandom_range(REG_COUNT, (1 << CFG_IDX_W) - 1)),
              CFG_DATA_W'($urandom));
    cfg_valid <= 1'b0;
  endtask

  // --------------------------------------------------------------------------
  // Receiver: random stall per result, quiet stretches, and one long hold-off
  // that backs the core up into its input channel.
  // --------------------------------------------------------------------------
  initial begin : receiver
    int n;
    int taken;
    taken = 0;
    wait (rst === 1'b0);
    forever begin
      if (hold_done < hold_asks) begin
        n = LONG_HOLD;
        hold_done++;
      end else begin
        n = rcv_quiet ? 0 : $urandom_range(0, 4);
      end
      if (n > 0) begin
        out_stall <= 1'b1;
        repeat (n) @(posedge clk);
      end
      out_stall <= 1'b0;
      do @(posedge clk); while (!out_valid);
      taken++;
      if (taken % 64 == 0) rcv_quiet = $urandom_range(0, 1);
    end
  end

  // --------------------------------------------------------------------------
  // Scoreboard: predict on every input transaction, check every output one.
  // Sampled right after the edge, so both see the values held at the edge.
  // --------------------------------------------------------------------------
  always @(posedge clk) begin : scoreboard
    out_t want;
    out_t got;
    if (!rst) begin
      if (in_valid && !in_stall) begin
        want = next_drive(in_data);
        if (row_known) want = row_want;   // typed row takes precedence
        drive_expected_q.push_back(want);
        if (in_data.func == FUNC_STOP) n_stops++;
        else                           n_samples++;
      end
      if (out_valid && !out_stall) begin
        got = out_data;
        n_results++;
        if (drive_expected_q.size() == 0) begin
          $error("unexpected result transaction: speed %0d duty %0d in1 %0b in2 %0b",
                 got.measured_speed, got.duty, got.bridge_in1, got.bridge_in2);
          fails++;
        end else begin
          want = drive_expected_q.pop_front();
          if (got.measured_speed !== want.measured_speed) begin
            $error("measured_speed: expected %0d, actual %0d",
                   want.measured_speed, got.measured_speed);
            fails++;
          end
          if (got.duty !== want.duty) begin
            $error("duty: expected %0d, actual %0d", want.duty, got.duty);
            fails++;
          end
          if (got.bridge_in1 !== want.bridge_in1) begin
            $error("bridge_in1: expected %0b, actual %0b", want.bridge_in1, got.bridge_in1);
            fails++;
          end
          if (got.bridge_in2 !== want.bridge_in2) begin
            $error("bridge_in2: expected %0b, actual %0b", want.bridge_in2, got.bridge_in2);
            fails++;
          end
        end
      end
    end
  end

  // watchdog
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d results outstanding",
               cycle_count, drive_expected_q.size());
      $display("== FAIL ==");
      $finish;
    end
  end

  // --------------------------------------------------------------------------
  // Stimulus
  // --------------------------------------------------------------------------
  plan_row_t plan[$];

  initial begin : stimulus
    bit writing;
    writing = 1'b0;

    // Directed table. Typed rows run at reset settings with all gains zero,
    // so every sample coasts and its speed is count * 6000 (saturated).
    plan = '{
      // stop before any sample, count ignored
      k_row(FUNC_STOP,   16'sh7FFF, 24'sd0,       1'b1, 1'b1),
      // first sample: derivative forced to zero
      k_row(FUNC_SAMPLE, 16'sd0,    24'sd0,       1'b0, 1'b0),
      k_row(FUNC_SAMPLE, 16'sh7FFF, 24'sh7FFFFF,  1'b0, 1'b0),
      k_row(FUNC_SAMPLE, 16'sh8000, 24'sh800000,  1'b0, 1'b0),
      k_row(FUNC_SAMPLE, 16'sd1,    24'sd6000,    1'b0, 1'b0),
      k_row(FUNC_SAMPLE, -16'sd1,   -24'sd6000,   1'b0, 1'b0),
      k_row(FUNC_STOP,   16'sh8000, 24'sd0,       1'b1, 1'b1),
      // tiny P gain: corrections below one still steer, duty stays 0
      w_row(REG_GAIN_P, 24'h000001),
      i_row(FUNC_SAMPLE, 16'sd0),
      i_row(FUNC_SAMPLE, 16'sd1),
      i_row(FUNC_SAMPLE, -16'sd1),
      // setpoint, scale, gains P and D and the limit at their top end, gain_i at its bottom
      w_row(REG_SETPOINT,       24'h7FFFFF),
      w_row(REG_SPEED_SCALE,    24'hFFFFFF),
      w_row(REG_GAIN_P,         24'h007FFF),
      w_row(REG_GAIN_I,         24'h008000),
      w_row(REG_GAIN_D,         24'h007FFF),
      w_row(REG_INTEGRAL_LIMIT, 24'h7FFFFF),
      w_row(CFG_IDX_UNUSED,     24'hFFFFFF),
      i_row(FUNC_SAMPLE, 16'sh7FFF),
      i_row(FUNC_SAMPLE, 16'sh8000),
      i_row(FUNC_SAMPLE, 16'sd0),
      i_row(FUNC_STOP,   16'sd0),
      i_row(FUNC_SAMPLE, 16'sd100),
      // zero periods and zero limit: no integral step, no derivative
      w_row(REG_SAMPLE_PERIOD,  24'h000000),
      w_row(REG_INVERSE_PERIOD, 24'h000000),
      w_row(REG_INTEGRAL_LIMIT, 24'h000000),
      w_row(REG_SETPOINT,       24'h800000),
      w_row(REG_SPEED_SCALE,    24'h000000),
      w_row(REG_GAIN_P,         24'h008000),
      i_row(FUNC_SAMPLE, 16'sd5),
      i_row(FUNC_SAMPLE, -16'sd5),
      i_row(FUNC_STOP,   -16'sd1),
      // slow loop with real PID action around a small setpoint
      w_row(REG_SAMPLE_PERIOD,  24'h00FFFF),
      w_row(REG_INVERSE_PERIOD, 24'h00FFFF),
      w_row(REG_INTEGRAL_LIMIT, 24'h001000),
      w_row(REG_SPEED_SCALE,    24'h000100),
      w_row(REG_SETPOINT,       24'h000A00),
      w_row(REG_GAIN_P,         24'h000100),
      w_row(REG_GAIN_I,         24'h000040),
      w_row(REG_GAIN_D,         24'h00FFFF),
      i_row(FUNC_SAMPLE, 16'sd10),
      i_row(FUNC_SAMPLE, 16'sd12),
      i_row(FUNC_SAMPLE, 16'sd8),
      i_row(FUNC_SAMPLE, -16'sd3),
      i_row(FUNC_SAMPLE, 16'sd0)
    };

    repeat (8) @(posedge clk);
    rst <= 1'b0;

    foreach (plan[k]) begin
      if (plan[k].kind == ROW_WRITE) begin
        // registers change only with the core idle
        if (!writing) wait_drain();
        writing = 1'b1;
        cfg_write(plan[k].idx, plan[k].val);
      end else begin
        if (writing) cfg_valid <= 1'b0;
        writing = 1'b0;
        send_item(plan[k].item, plan[k].known, plan[k].want);
      end
    end

    // Random phases, each under fresh register settings; the last one pins
    // every register at an extreme.
    for (int ph = 0; ph < NUM_PHASES; ph++) begin
      program_phase(ph);
      send_quiet = (ph % 3 == 1);
      for (int n = 0; n < PHASE_ITEMS; n++) begin
        if (ph == 2 && n == 20) begin
          // back-to-back offers while the receiver sits on its stall
          send_quiet = 1'b1;
          hold_asks++;
        end
        if (ph == 2 && n == 60) send_quiet = 1'b0;
        if (ph == 3 && n == 50) wait_drain();
        send_item(rand_item(), 1'b0, '0);
      end
    end

    wait_drain();
    repeat (TAIL_CYCLES) @(posedge clk);
    if (drive_expected_q.size() != 0) begin
      $error("%0d expected results never arrived", drive_expected_q.size());
      fails++;
    end

    $display("run covered %0d control samples and %0d stop items over %0d register writes",
             n_samples, n_stops, n_writes);
    $display("%0d results checked, %0d with saturated speed, %0d mismatches",
             n_results, n_speed_sat, fails);
    if (fails == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
